// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/hsv2rgb_pkg.sv
// Types, constants and helpers for the HSV to RGB converter.
package hsv2rgb_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int HUE_W       = 13;
  localparam int CH_W        = 17;                 // saturation, value, colors
  localparam int REM_W       = 10;                 // position inside a sector
  localparam int SEC_W       = 3;
  localparam int PROD_W      = CH_W + REM_W;       // s * rem
  localparam int MUL_W       = 2 * CH_W;           // v * (1 - x)
  localparam int NUM_SECTORS = 6;
  localparam int HUE_SECTOR  = 960;                // 60 degrees
  localparam int HUE_FULL    = NUM_SECTORS * HUE_SECTOR;

  localparam logic [CH_W-1:0] ONE = CH_W'(1 << FRAC_BITS);

  // x / 960 = (x >> 6) / 15, done as a multiply by a rounded-up reciprocal.
  localparam int DIV_PRE = 6;
  localparam int DIV_ODD = HUE_SECTOR >> DIV_PRE;
  localparam int DIV_K   = 24;
  localparam int DIV_Y_W = PROD_W - DIV_PRE;
  localparam int DIV_M_W = 21;
  localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'(((1 << DIV_K) + DIV_ODD - 1) / DIV_ODD);

  // Sector codes, named by their (red, green, blue) pattern.
  localparam logic [SEC_W-1:0] SEC_VTP = 3'd0;
  localparam logic [SEC_W-1:0] SEC_QVP = 3'd1;
  localparam logic [SEC_W-1:0] SEC_PVT = 3'd2;
  localparam logic [SEC_W-1:0] SEC_PQV = 3'd3;
  localparam logic [SEC_W-1:0] SEC_TPV = 3'd4;
  localparam logic [SEC_W-1:0] SEC_VPQ = 3'd5;

  typedef logic [CH_W-1:0] chan_t;

  // Per-item control carried down the pipe.
  typedef struct packed {
    logic [SEC_W-1:0] sector;
    logic             in_range;
    logic             s_zero;
  } ctl_t;

  function automatic logic [SEC_W-1:0] hue_sector(input logic [HUE_W-1:0] h);
    logic [SEC_W-1:0] sec;
    sec = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (h >= HUE_W'(k * HUE_SECTOR)) sec = SEC_W'(k);
    end
    return sec;
  endfunction

  function automatic chan_t clamp_one(input chan_t x);
    return (x > ONE) ? ONE : x;
  endfunction

endpackage

// File: hw/rtl/hsv2rgb_if.sv
// Valid/ready channel interfaces for the HSV input and RGB result.
interface hsv2rgb_in_if import hsv2rgb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HUE_W-1:0]  hue;
  logic [CH_W-1:0]   saturation;
  logic [CH_W-1:0]   brightness;

  modport source(output valid, hue, saturation, brightness, input ready);
  modport sink(input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if import hsv2rgb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

// File: hw/rtl/hsv2rgb_div960.sv
// Exact floor division by 960 through a reciprocal multiply.
module hsv2rgb_div960 import hsv2rgb_pkg::*; (
  input  logic [PROD_W-1:0] num,
  output chan_t             quo
);

  logic [DIV_Y_W-1:0]         y;
  logic [DIV_Y_W+DIV_M_W-1:0] prod;

  // Exact for every num below 2^26 (s * 960 at most).
  assign y    = num[PROD_W-1:DIV_PRE];
  assign prod = (DIV_Y_W + DIV_M_W)'(y) * (DIV_Y_W + DIV_M_W)'(DIV_M);
  assign quo  = prod[DIV_K +: CH_W];

endmodule

// File: hw/rtl/hsv_to_rgb_converter_unit.sv
// Top level: pipelined HSV to RGB color converter.
//
// Usage:
//   in_ch  (sink)   : hue in 1/16 degree, saturation and brightness in
//                     fixed point with 16 fraction bits (65536 = 1.0).
//   out_ch (source) : red, green, blue in the same fixed-point format.
//   An item moves on a channel at a rising clk edge with valid and ready high.
// Throughput: one item per cycle while out_ch.ready is high. Stages 2 to 4
//   each hold one level of multiplication (s*rem, the divide-by-960
//   reciprocal, v*(1-x)), and five register stages carry the item through.
// Order: stage 1 decode, stage 2 s*rem, stage 3 divide, stage 4 p, q, t,
//   then the output register, which drives out_ch.
// Stalls: each stage loads when it is empty or the stage after it moves,
//   so bubbles close up and in_ch stays ready while the pipe has room; a
//   held result keeps its value until taken.
// Reset (rst_n low, synchronous): all stage valid bits clear; no item is
//   in flight afterwards. Nothing is kept between items.
// Special cases: a hue of a full turn wraps to zero; a hue past a full turn
//   gives black, or gray (all channels = value) when saturation is zero.
// Saturation and brightness above 1.0 are clamped to 1.0.
module hsv_to_rgb_converter_unit import hsv2rgb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  hsv2rgb_in_if.sink   in_ch,
  hsv2rgb_out_if.source out_ch
);

  // Stage enables: load when empty or when downstream moves.
  logic en0, en1, en2, en3, en4;

  // Stage 1: decoded hue, clamped inputs
  logic             s1_valid_r;
  chan_t            s1_s_r, s1_v_r;
  logic [REM_W-1:0] s1_rem_r;
  ctl_t             s1_ctl_r;

  // Stage 2: s * rem and s * (960 - rem)
  logic              s2_valid_r;
  logic [PROD_W-1:0] s2_pf_r, s2_pf1_r;
  chan_t             s2_oms_r, s2_v_r;
  ctl_t              s2_ctl_r;

  // Stage 3: sf, sf1 after the divide by 960
  logic  s3_valid_r;
  chan_t s3_sf_r, s3_sf1_r, s3_oms_r, s3_v_r;
  ctl_t  s3_ctl_r;

  // Stage 4: p, q, t
  logic  s4_valid_r;
  chan_t s4_p_r, s4_q_r, s4_t_r, s4_v_r;
  ctl_t  s4_ctl_r;

  // Output register
  logic  out_valid_r;
  chan_t out_red_r, out_green_r, out_blue_r;

  assign en4 = !out_valid_r || out_ch.ready;
  assign en3 = !s4_valid_r  || en4;
  assign en2 = !s3_valid_r  || en3;
  assign en1 = !s2_valid_r  || en2;
  assign en0 = !s1_valid_r  || en1;

  assign in_ch.ready  = en0;
  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = out_red_r;
  assign out_ch.green = out_green_r;
  assign out_ch.blue  = out_blue_r;

  // ---- Stage 1 decode -------------------------------------------------
  logic [HUE_W-1:0] hue_fold;
  logic [SEC_W-1:0] sec_nxt;
  logic [HUE_W-1:0] base;
  logic [HUE_W-1:0] rem_full;
  chan_t            s_nxt, v_nxt;
  ctl_t             s1_ctl_nxt;
  logic [REM_W-1:0] s1_rem_nxt;

  always_comb begin
    // full turn wraps to zero
    hue_fold = (in_ch.hue == HUE_W'(HUE_FULL)) ? '0 : in_ch.hue;
    sec_nxt  = hue_sector(hue_fold);
    base     = HUE_W'(sec_nxt) * HUE_W'(HUE_SECTOR);
    rem_full = hue_fold - base;
    s1_rem_nxt = rem_full[REM_W-1:0];
    s_nxt    = clamp_one(in_ch.saturation);
    v_nxt    = clamp_one(in_ch.brightness);
    s1_ctl_nxt.sector   = sec_nxt;
    s1_ctl_nxt.in_range = (hue_fold < HUE_W'(HUE_FULL));
    s1_ctl_nxt.s_zero   = (s_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en0) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      s1_s_r   <= s_nxt;
      s1_v_r   <= v_nxt;
      s1_rem_r <= s1_rem_nxt;
      s1_ctl_r <= s1_ctl_nxt;
    end
  end

  // ---- Stage 2: saturation times sector fraction ----------------------
  logic [REM_W-1:0]  rem_c;
  logic [PROD_W-1:0] s2_pf_nxt, s2_pf1_nxt;

  assign rem_c      = REM_W'(HUE_SECTOR) - s1_rem_r;
  assign s2_pf_nxt  = PROD_W'(s1_s_r) * PROD_W'(s1_rem_r);
  assign s2_pf1_nxt = PROD_W'(s1_s_r) * PROD_W'(rem_c);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en1) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s2_pf_r  <= s2_pf_nxt;
      s2_pf1_r <= s2_pf1_nxt;
      s2_oms_r <= ONE - s1_s_r;
      s2_v_r   <= s1_v_r;
      s2_ctl_r <= s1_ctl_r;
    end
  end

  // ---- Stage 3: divide by one sector width ----------------------------
  chan_t s3_sf_nxt, s3_sf1_nxt;

  hsv2rgb_div960 u_div_f (
    .num (s2_pf_r),
    .quo (s3_sf_nxt)
  );

  hsv2rgb_div960 u_div_f1 (
    .num (s2_pf1_r),
    .quo (s3_sf1_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (en2) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s3_sf_r  <= s3_sf_nxt;
      s3_sf1_r <= s3_sf1_nxt;
      s3_oms_r <= s2_oms_r;
      s3_v_r   <= s2_v_r;
      s3_ctl_r <= s2_ctl_r;
    end
  end

  // ---- Stage 4: p, q, t = v * (1 - x), truncated -----------------------
  logic [MUL_W-1:0] p_prod, q_prod, t_prod;

  assign p_prod = MUL_W'(s3_v_r) * MUL_W'(s3_oms_r);
  assign q_prod = MUL_W'(s3_v_r) * MUL_W'(ONE - s3_sf_r);
  assign t_prod = MUL_W'(s3_v_r) * MUL_W'(ONE - s3_sf1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (en3) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s4_p_r   <= p_prod[FRAC_BITS +: CH_W];
      s4_q_r   <= q_prod[FRAC_BITS +: CH_W];
      s4_t_r   <= t_prod[FRAC_BITS +: CH_W];
      s4_v_r   <= s3_v_r;
      s4_ctl_r <= s3_ctl_r;
    end
  end

  // ---- Output: sector select ------------------------------------------
  chan_t red_nxt, green_nxt, blue_nxt;

  always_comb begin
    red_nxt   = '0;
    green_nxt = '0;
    blue_nxt  = '0;
    if (s4_ctl_r.in_range) begin
      case (s4_ctl_r.sector)
        SEC_VTP: begin
          red_nxt = s4_v_r; green_nxt = s4_t_r; blue_nxt = s4_p_r;
        end
        SEC_QVP: begin
          red_nxt = s4_q_r; green_nxt = s4_v_r; blue_nxt = s4_p_r;
        end
        SEC_PVT: begin
          red_nxt = s4_p_r; green_nxt = s4_v_r; blue_nxt = s4_t_r;
        end
        SEC_PQV: begin
          red_nxt = s4_p_r; green_nxt = s4_q_r; blue_nxt = s4_v_r;
        end
        SEC_TPV: begin
          red_nxt = s4_t_r; green_nxt = s4_p_r; blue_nxt = s4_v_r;
        end
        default: begin
          red_nxt = s4_v_r; green_nxt = s4_p_r; blue_nxt = s4_q_r;
        end
      endcase
    end else if (s4_ctl_r.s_zero) begin
      // hue past a full turn, no saturation: gray
      red_nxt   = s4_v_r;
      green_nxt = s4_v_r;
      blue_nxt  = s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en4) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
    end
  end

endmodule

// File: hw/rtl/hsv2rgb_checker.sv
// Port-level checker for the HSV to RGB converter, with its bind.
`include "assert_macros.svh"

module hsv2rgb_checker import hsv2rgb_pkg::*; (
  input logic  clk,
  input logic  rst_n,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input chan_t out_red,
  input chan_t out_green,
  input chan_t out_blue
);

  logic              colors_in_range;
  logic [3*CH_W-1:0] out_rgb;

  assign colors_in_range = (out_red <= ONE) && (out_green <= ONE) && (out_blue <= ONE);
  assign out_rgb         = {out_red, out_green, out_blue};

  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid, "result valid after reset")

  `ASSERT_CLK(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready,
              "input stalled with empty output")

  `ASSERT_CLK(a_range, clk, rst_n, out_valid |-> colors_in_range, "color above 1.0")

  `ASSERT_CLK(a_hold, clk, rst_n,
              out_valid && !out_ready |=> out_valid && $stable(out_rgb),
              "stalled result changed")

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_checker u_hsv2rgb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_red   (out_ch.red),
  .out_green (out_ch.green),
  .out_blue  (out_ch.blue)
);
